/* hdl/tshc_pkg.sv */
// ----------------------------------------------------------------------------
// tshc_pkg
// shared types and constants of the strip hit clustering block
// ----------------------------------------------------------------------------
package tshc_pkg;

  // fixed field widths
  localparam int StripW   = 11;
  localparam int ReqClkW  = 10;
  localparam int TimeW    = 28;
  localparam int PwW      = 10;
  localparam int GainW    = 16;
  localparam int OffW     = 20;
  localparam int SiuW     = 12;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 20;
  localparam int InDataW  = 24;
  localparam int OutDataW = 56;
  localparam int OutPadW  = OutDataW - (1 + StripW + TimeW + PwW);

  localparam logic [TimeW-1:0] TIME_MAX = '1;

  // register reset values
  localparam logic [SiuW-1:0] STRIPS_IN_USE_RST  = 12'd384;
  localparam logic [OffW-1:0] ANODE_OFFSET_RST   = 20'd84539;
  localparam logic [GainW-1:0] ANODE_GAIN_RST    = 16'd28373;
  localparam logic [OffW-1:0] CATHODE_OFFSET_RST = 20'd45717;
  localparam logic [GainW-1:0] CATHODE_GAIN_RST  = 16'd27391;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_STRIPS_IN_USE  = 3'd0,
    CFG_ANODE_OFFSET   = 3'd1,
    CFG_ANODE_GAIN     = 3'd2,
    CFG_CATHODE_OFFSET = 3'd3,
    CFG_CATHODE_GAIN   = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    REQ_HIT   = 1'b0,
    REQ_FLUSH = 1'b1
  } req_t;

  typedef enum logic {
    CAUSE_GAP   = 1'b0,
    CAUSE_FLUSH = 1'b1
  } cause_t;

  // identity of a closed pulse, carried along the time pipeline
  typedef struct packed {
    cause_t            cause;
    logic [StripW-1:0] strip;
    logic              side;
  } pulse_tag_t;

endpackage

/* hdl/tshc_store.sv */
// ----------------------------------------------------------------------------
// tshc_store
// per-strip first/last clock memory with write bypass and clearing sweep
// ----------------------------------------------------------------------------
module tshc_store
  import tshc_pkg::*;
#(
  parameter int STRIP_CAPACITY = 2048,
  parameter int CLOCK_BITS     = 10,
  parameter int AW             = $clog2(2 * STRIP_CAPACITY)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  output logic                    busy,
  input  logic                    rd_en,
  input  logic [AW-1:0]           rd_addr,
  output logic [2*CLOCK_BITS-1:0] rd_data,   // {first, last}
  input  logic                    wr_en,
  input  logic [AW-1:0]           wr_addr,
  input  logic [2*CLOCK_BITS-1:0] wr_data    // {first, last}
);

  localparam int Depth = 2 * STRIP_CAPACITY;
  localparam int DW    = 2 * CLOCK_BITS;
  localparam logic [DW-1:0] ClearWord = {{CLOCK_BITS{1'b1}}, {CLOCK_BITS{1'b0}}};

  logic [DW-1:0] mem [Depth];

  logic          clearing_r;
  logic [AW-1:0] clr_cnt_r;
  logic [DW-1:0] rd_q_r;
  logic          byp_hit_r;
  logic [DW-1:0] byp_data_r;

  logic          we;
  logic [AW-1:0] wa;
  logic [DW-1:0] wd;

  assign busy = clearing_r;
  assign we   = clearing_r | wr_en;
  assign wa   = clearing_r ? clr_cnt_r : wr_addr;
  assign wd   = clearing_r ? ClearWord : wr_data;

  // sweep every entry to its reset value after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
      if (clr_cnt_r == AW'(Depth - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // a write landing on the entry being read in the same cycle is bypassed
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r     <= mem[rd_addr];
      byp_hit_r  <= wr_en && (wr_addr == rd_addr);
      byp_data_r <= wr_data;
    end
  end

  assign rd_data = byp_hit_r ? byp_data_r : rd_q_r;

endmodule

/* hdl/tshc_time.sv */
// ----------------------------------------------------------------------------
// tshc_time
// time-walk correction pipeline and output register
// ----------------------------------------------------------------------------
module tshc_time
  import tshc_pkg::*;
#(
  parameter int CLOCK_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pulse_tag_t            tag,
  input  logic [CLOCK_BITS-1:0] first,
  input  logic [CLOCK_BITS-1:0] width,
  input  logic [GainW-1:0]      gain,
  input  logic [OffW-1:0]       offset,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OutDataW-1:0]   out_tdata,
  output logic                  out_tuser
);

  localparam int PW = CLOCK_BITS + GainW;
  localparam int BW = CLOCK_BITS + 17;
  localparam int SW = (CLOCK_BITS + 18 > TimeW + 1) ? CLOCK_BITS + 18 : TimeW + 1;

  logic             a_valid_r;
  pulse_tag_t       a_tag_r;
  logic [PW-1:0]    a_prod_r;
  logic [BW-1:0]    a_base_r;
  logic [PwW-1:0]   a_pw_r;

  logic             o_valid_r;
  pulse_tag_t       o_tag_r;
  logic [TimeW-1:0] o_time_r;
  logic [PwW-1:0]   o_pw_r;

  logic             o_rdy;
  logic             a_rdy;
  logic [SW-1:0]    sum;
  logic [TimeW-1:0] time_nxt;

  assign o_rdy    = !o_valid_r || out_tready;
  assign a_rdy    = !a_valid_r || o_rdy;
  assign in_ready = a_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (a_rdy) begin
        a_valid_r <= in_valid;
      end
      if (o_rdy) begin
        o_valid_r <= a_valid_r;
      end
    end
  end

  // product and base in one stage, sum and clamp in the next
  always_ff @(posedge clk) begin
    if (a_rdy && in_valid) begin
      a_tag_r  <= tag;
      a_prod_r <= PW'(gain) * PW'(width);
      a_base_r <= BW'({first, 16'b0}) + BW'(offset);
      a_pw_r   <= PwW'(width);
    end
  end

  assign sum      = SW'(a_base_r) + SW'(a_prod_r);
  assign time_nxt = (sum > SW'(TIME_MAX)) ? TIME_MAX : TimeW'(sum);

  always_ff @(posedge clk) begin
    if (o_rdy && a_valid_r) begin
      o_tag_r  <= a_tag_r;
      o_time_r <= time_nxt;
      o_pw_r   <= a_pw_r;
    end
  end

  assign out_tvalid = o_valid_r;
  assign out_tdata  = {{OutPadW{1'b0}}, o_pw_r, o_time_r, o_tag_r.strip, o_tag_r.side};
  assign out_tuser  = o_tag_r.cause;

endmodule

/* hdl/tot_strip_hit_clustering.sv */
// ----------------------------------------------------------------------------
// tot_strip_hit_clustering
// time-over-threshold strip hit clustering with time-walk correction
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake           | beat contents (low bit first)
//  --------+-----+---------------------+-----------------------------------------
//  in_     | in  | in_tvalid/in_tready | tdata: side, strip, clock_req
//          |     |                     | tuser: req_type (0 hit, 1 flush)
//  out_    | out | out_tvalid/tready   | tdata: out_side, out_strip,
//          |     |                     |        corrected_time, pulse_width
//          |     |                     | tuser: cause (0 gap, 1 flush)
//  cfg_    | in  | cfg_valid/cfg_ready | cfg_index, cfg_wdata
//
//  one beat per cycle sustained while the output is not stalled; a result
//  passes the update stage (memory read), the multiply stage and the output
//  register (sum and clamp); the per-strip read-modify-write closes through a
//  write bypass in the store, so beats on the same strip may follow back to back
//  after reset a clearing sweep writes all 2*STRIP_CAPACITY entries (4096 by
//  default), one per cycle, with in_tready low; cfg writes still taken
//  a stalled output backs up through the time pipeline to in_tready
//
module tot_strip_hit_clustering
  import tshc_pkg::*;
#(
  parameter int STRIP_CAPACITY = 2048,
  parameter int CLOCK_BITS     = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  // input beats
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,   // side, strip[10:0], clock_req[9:0], zero pad
  input  logic                in_tuser,   // req_type
  // result beats
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,  // out_side, out_strip[10:0], corrected_time[27:0],
                                          // pulse_width[9:0], zero pad
  output logic                out_tuser,  // cause
  // register writes
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  localparam int CB = CLOCK_BITS;
  localparam int AW = $clog2(2 * STRIP_CAPACITY);

  // configuration registers
  logic [SiuW-1:0]  strips_in_use_r;
  logic [OffW-1:0]  anode_offset_r;
  logic [GainW-1:0] anode_gain_r;
  logic [OffW-1:0]  cathode_offset_r;
  logic [GainW-1:0] cathode_gain_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strips_in_use_r  <= STRIPS_IN_USE_RST;
      anode_offset_r   <= ANODE_OFFSET_RST;
      anode_gain_r     <= ANODE_GAIN_RST;
      cathode_offset_r <= CATHODE_OFFSET_RST;
      cathode_gain_r   <= CATHODE_GAIN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_STRIPS_IN_USE:  strips_in_use_r  <= cfg_wdata[SiuW-1:0];
        CFG_ANODE_OFFSET:   anode_offset_r   <= cfg_wdata[OffW-1:0];
        CFG_ANODE_GAIN:     anode_gain_r     <= cfg_wdata[GainW-1:0];
        CFG_CATHODE_OFFSET: cathode_offset_r <= cfg_wdata[OffW-1:0];
        CFG_CATHODE_GAIN:   cathode_gain_r   <= cfg_wdata[GainW-1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // input beat unpacking
  logic              in_side;
  logic [StripW-1:0] in_strip;
  logic [CB-1:0]     in_clk;
  logic              in_range;
  logic [AW-1:0]     in_addr;
  logic              in_acc;

  assign in_side  = in_tdata[0];
  assign in_strip = in_tdata[StripW:1];
  // clock masked (or widened) to the store width
  assign in_clk   = CB'(in_tdata[StripW+ReqClkW:StripW+1]);
  assign in_range = ({1'b0, in_strip} < strips_in_use_r) &&
                    (32'(in_strip) < STRIP_CAPACITY);
  // anode strips in the lower half of the store, cathode strips above
  assign in_addr  = in_side ? AW'(STRIP_CAPACITY) + AW'(in_strip) : AW'(in_strip);
  assign in_acc   = in_tvalid && in_tready;

  // update stage: holds the item whose store entry is being read
  logic              s1_valid_r;
  req_t              s1_req_r;
  logic              s1_side_r;
  logic [StripW-1:0] s1_strip_r;
  logic [CB-1:0]     s1_clk_r;
  logic [AW-1:0]     s1_addr_r;
  logic              s1_valid_nxt;

  logic              busy;
  logic [2*CB-1:0]   rd_word;
  logic [CB-1:0]     cur_first;
  logic [CB-1:0]     cur_last;
  logic [CB-1:0]     new_first;
  logic [CB-1:0]     new_last;
  logic [CB-1:0]     gap_first;
  logic [CB-1:0]     width;
  logic              emit;
  cause_t            cause;
  logic              t_ready;
  logic              s1_go;
  logic              s1_load;
  pulse_tag_t        tag;

  assign cur_first = rd_word[2*CB-1:CB];
  assign cur_last  = rd_word[CB-1:0];
  // wraps on an inverted entry, as the store width does
  assign width     = cur_last - cur_first;

  always_comb begin
    gap_first = cur_first;
    new_first = {CB{1'b1}};
    new_last  = '0;
    emit      = 1'b0;
    cause     = CAUSE_GAP;
    if (s1_req_r == REQ_FLUSH) begin
      // pending pulse when last has caught up with first; entry cleared
      emit  = cur_last >= cur_first;
      cause = CAUSE_FLUSH;
    end else begin
      // a hit clock beyond the one just after a live pulse's last closes it
      emit = (cur_last != '0) &&
             (({1'b0, cur_last} + (CB+1)'(2)) <= {1'b0, s1_clk_r});
      if (emit) begin
        gap_first = s1_clk_r;
      end
      new_last  = (cur_last <= s1_clk_r) ? s1_clk_r : cur_last;
      new_first = (gap_first >= s1_clk_r) ? s1_clk_r : gap_first;
    end
  end

  // an item with a pulse to report waits for room in the time pipeline
  assign s1_go     = s1_valid_r && (!emit || t_ready);
  assign s1_load   = !s1_valid_r || s1_go;
  assign in_tready = !busy && s1_load;
  assign s1_valid_nxt = in_acc && in_range;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && s1_valid_nxt) begin
      s1_req_r   <= req_t'(in_tuser);
      s1_side_r  <= in_side;
      s1_strip_r <= in_strip;
      s1_clk_r   <= in_clk;
      s1_addr_r  <= in_addr;
    end
  end

  tshc_store #(
    .STRIP_CAPACITY (STRIP_CAPACITY),
    .CLOCK_BITS     (CLOCK_BITS),
    .AW             (AW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .busy    (busy),
    .rd_en   (s1_load && s1_valid_nxt),
    .rd_addr (in_addr),
    .rd_data (rd_word),
    .wr_en   (s1_go),
    .wr_addr (s1_addr_r),
    .wr_data ({new_first, new_last})
  );

  assign tag.cause = cause;
  assign tag.strip = s1_strip_r;
  assign tag.side  = s1_side_r;

  tshc_time #(
    .CLOCK_BITS (CLOCK_BITS)
  ) u_time (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (s1_go && emit),
    .in_ready   (t_ready),
    .tag        (tag),
    .first      (cur_first),
    .width      (width),
    .gain       (s1_side_r ? cathode_gain_r : anode_gain_r),
    .offset     (s1_side_r ? cathode_offset_r : anode_offset_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

/* hdl/tshc_checker.sv */
// ----------------------------------------------------------------------------
// tshc_checker
// port-level checks of the strip hit clustering block
// ----------------------------------------------------------------------------
module tshc_checker
  import tshc_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_tready,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [OutDataW-1:0] out_tdata,
  input logic                out_tuser
);

  // a stalled result beat keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // the clearing sweep holds off input right after reset
  a_sweep_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input taken before store sweep");

  // padding above pulse_width is always zero on a result beat
  a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OutDataW-1:OutDataW-OutPadW] == '0)
    else $error("nonzero padding in result beat");

endmodule

bind tot_strip_hit_clustering tshc_checker u_tshc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

/* test/tot_strip_hit_clustering_tb.sv */
// ----------------------------------------------------------------------------
// tot_strip_hit_clustering_tb
// self-checking bench for the strip hit clustering block
// ----------------------------------------------------------------------------
// streams hit and flush beats into the block under several register settings,
// tracks first/last clock per side and strip in a local copy of the pulse
// store, predicts every closed pulse with its corrected time, and checks each
// result beat in order against those predictions
// ----------------------------------------------------------------------------
module tot_strip_hit_clustering_tb;
  import tshc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD    = 10;
  localparam int CYCLE_LIMIT   = 600_000;
  localparam int SETTLE_CYCLES = 8;      // lets the pipeline run dry after the last beat
  localparam int MAX_EV_STRIPS = 6;
  localparam int HOLD_MARK_A   = 400;    // input beats seen before each long hold-off
  localparam int HOLD_MARK_B   = 1100;
  localparam int MAX_PRINTS    = 20;
  localparam int STORE_DEPTH   = 2 * (1 << StripW);
  localparam int OUT_STRIP_LO  = 1;
  localparam int OUT_TIME_LO   = OUT_STRIP_LO + StripW;
  localparam int OUT_PW_LO     = OUT_TIME_LO + TimeW;
  localparam int IN_PAD_W      = InDataW - 1 - StripW - ReqClkW;

  // one input beat as queued for the driver
  typedef struct packed {
    req_t                req;
    logic                side;
    logic [StripW-1:0]   strip;
    logic [ReqClkW-1:0]  clk_v;
  } strip_beat_t;

  // one closed pulse as it should leave the block
  typedef struct packed {
    logic              side;
    logic [StripW-1:0] strip;
    logic [TimeW-1:0]  ctime;
    logic [PwW-1:0]    width;
    cause_t            cause;
  } pulse_rec_t;

  // dut ports; the inputs are driven to known values from time zero
  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata   = '0;
  logic                in_tuser   = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                out_tuser;
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index  = '0;
  logic [CfgDataW-1:0] cfg_wdata  = '0;

  // local copy of the registers and the pulse store
  logic [SiuW-1:0]     siu_q       = STRIPS_IN_USE_RST;
  logic [OffW-1:0]     anode_off_q = ANODE_OFFSET_RST;
  logic [GainW-1:0]    anode_gain_q = ANODE_GAIN_RST;
  logic [OffW-1:0]     cath_off_q  = CATHODE_OFFSET_RST;
  logic [GainW-1:0]    cath_gain_q = CATHODE_GAIN_RST;
  logic [ReqClkW-1:0]  last_clk_q  [0:STORE_DEPTH-1];
  logic [ReqClkW-1:0]  first_clk_q [0:STORE_DEPTH-1];

  strip_beat_t beats_to_send[$];
  pulse_rec_t  pulses_due[$];

  // bookkeeping
  int  cycle_count     = 0;
  int  items_in        = 0;
  int  ignored_in      = 0;
  int  pulses_seen     = 0;
  int  flush_pulses    = 0;
  int  mismatches      = 0;
  int  in_range_queued = 0;
  int  settings_seen   = 0;
  int  holds_done      = 0;
  bit  in_fire         = 1'b0;

  // driver and receiver private state
  strip_beat_t tx_beat;
  int  tx_gap_left  = 0;
  int  tx_calm_left = 0;
  int  rx_stall_left = 0;
  int  rx_calm_left  = 0;
  int  hold_left     = 0;

  tot_strip_hit_clustering uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  initial begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      last_clk_q[i]  = '0;
      first_clk_q[i] = '1;
    end
  end

  // --------------------------------------------------------------------------
  // prediction
  // --------------------------------------------------------------------------

  // corrected start: first + offset + gain * width, Q.16, clamped to 28 bits
  function automatic pulse_rec_t close_pulse(input logic side,
                                             input logic [StripW-1:0] strip,
                                             input logic [ReqClkW-1:0] last_c,
                                             input logic [ReqClkW-1:0] first_c,
                                             input cause_t why);
    pulse_rec_t  p;
    logic [63:0] start_fx;
    logic [63:0] off_fx;
    logic [63:0] gain_fx;
    logic [63:0] width_fx;
    logic [63:0] sum_fx;
    p.side   = side;
    p.strip  = strip;
    p.cause  = why;
    p.width  = last_c - first_c;
    start_fx = 64'(first_c);
    start_fx = start_fx << 16;
    off_fx   = side ? 64'(cath_off_q) : 64'(anode_off_q);
    gain_fx  = side ? 64'(cath_gain_q) : 64'(anode_gain_q);
    width_fx = 64'(p.width);
    sum_fx   = start_fx + off_fx + gain_fx * width_fx;
    p.ctime  = (sum_fx > 64'(TIME_MAX)) ? TIME_MAX : sum_fx[TimeW-1:0];
    return p;
  endfunction

  // per-strip read-modify-write of the pulse store for one accepted beat
  function automatic void track_strip_beat(input req_t req, input logic side,
                                           input logic [StripW-1:0] strip,
                                           input logic [ReqClkW-1:0] clk_v);
    logic [StripW:0]    idx;
    logic [ReqClkW-1:0] last_c;
    logic [ReqClkW-1:0] first_c;
    if ({1'b0, strip} >= siu_q) begin
      ignored_in++;
      return;
    end
    idx     = {side, strip};
    last_c  = last_clk_q[idx];
    first_c = first_clk_q[idx];
    if (req == REQ_FLUSH) begin
      // anything pending leaves, the entry is cleared either way
      if (last_c >= first_c)
        pulses_due = {pulses_due, close_pulse(side, strip, last_c, first_c, CAUSE_FLUSH)};
      last_clk_q[idx]  = '0;
      first_clk_q[idx] = '1;
      return;
    end
    // a hit clock beyond the one just after a nonzero last closes the pulse
    if (last_c != '0 && ({1'b0, last_c} + 11'd2) <= {1'b0, clk_v}) begin
      pulses_due = {pulses_due, close_pulse(side, strip, last_c, first_c, CAUSE_GAP)};
      first_c = clk_v;
    end
    if (last_c <= clk_v)
      last_c = clk_v;
    if (first_c >= clk_v)
      first_c = clk_v;
    last_clk_q[idx]  = last_c;
    first_clk_q[idx] = first_c;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < MAX_PRINTS)
      $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // rising edge: accepted beats feed the predictor, results are checked
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    pulse_rec_t want;
    cycle_count++;
    in_fire = rst_n && in_tvalid && in_tready;
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_STRIPS_IN_USE:  siu_q        = cfg_wdata[SiuW-1:0];
        CFG_ANODE_OFFSET:   anode_off_q  = cfg_wdata[OffW-1:0];
        CFG_ANODE_GAIN:     anode_gain_q = cfg_wdata[GainW-1:0];
        CFG_CATHODE_OFFSET: cath_off_q   = cfg_wdata[OffW-1:0];
        CFG_CATHODE_GAIN:   cath_gain_q  = cfg_wdata[GainW-1:0];
        default: ;  // writes past the last register are dropped
      endcase
    end
    if (in_fire) begin
      items_in++;
      track_strip_beat(req_t'(in_tuser), in_tdata[0], in_tdata[StripW:1],
                       in_tdata[StripW+ReqClkW:StripW+1]);
    end
    if (rst_n && out_tvalid && out_tready) begin
      pulses_seen++;
      if (pulses_due.size() == 0) begin
        report_mismatch("result beat with nothing pending", 64'(out_tdata), '0);
      end else begin
        want = pulses_due.pop_front();
        if (want.cause == CAUSE_FLUSH)
          flush_pulses++;
        if (out_tdata[0] !== want.side)
          report_mismatch("out_side", 64'(out_tdata[0]), 64'(want.side));
        if (out_tdata[OUT_TIME_LO-1:OUT_STRIP_LO] !== want.strip)
          report_mismatch("out_strip", 64'(out_tdata[OUT_TIME_LO-1:OUT_STRIP_LO]),
                          64'(want.strip));
        if (out_tdata[OUT_PW_LO-1:OUT_TIME_LO] !== want.ctime)
          report_mismatch("corrected_time", 64'(out_tdata[OUT_PW_LO-1:OUT_TIME_LO]),
                          64'(want.ctime));
        if (out_tdata[OUT_PW_LO+PwW-1:OUT_PW_LO] !== want.width)
          report_mismatch("pulse_width", 64'(out_tdata[OUT_PW_LO+PwW-1:OUT_PW_LO]),
                          64'(want.width));
        if (out_tuser !== want.cause)
          report_mismatch("cause", 64'(out_tuser), 64'(want.cause));
      end
    end
  end

  // mostly back to back, some short gaps, a few long ones, and now and then
  // a calm stretch with no gaps at all
  function automatic int pick_gap(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r == 0)
      calm_left = $urandom_range(30, 80);
    if (r < 60)
      return 0;
    if (r < 93)
      return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // --------------------------------------------------------------------------
  // falling edge: input driver, fed from the beat queue
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (in_tvalid && !in_fire) begin
      // beat still offered, hold it
    end else if (tx_gap_left != 0) begin
      tx_gap_left--;
      in_tvalid <= 1'b0;
    end else if (beats_to_send.size() != 0) begin
      tx_beat = beats_to_send.pop_front();
      in_tdata  <= {{IN_PAD_W{1'b0}}, tx_beat.clk_v, tx_beat.strip, tx_beat.side};
      in_tuser  <= tx_beat.req;
      in_tvalid <= 1'b1;
      tx_gap_left = pick_gap(tx_calm_left);
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // long hold-off counter: two long stretches that let the pipeline back up
  // into in_tready while beats keep coming
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
    end else if (holds_done < 2 &&
                 items_in >= ((holds_done == 0) ? HOLD_MARK_A : HOLD_MARK_B)) begin
      holds_done++;
      hold_left = $urandom_range(300, 500);
    end
  end

  // --------------------------------------------------------------------------
  // falling edge: result receiver with random stalls, quiet during a hold-off
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
    end else if (rx_stall_left != 0) begin
      rx_stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      rx_stall_left = pick_gap(rx_calm_left);
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT)
      @(posedge clk);
    $display("watchdog expired after %0d cycles", cycle_count);
    $display("FAIL tot_strip_hit_clustering");
    $finish;
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_beat(input req_t req, input logic side,
                            input logic [StripW-1:0] strip,
                            input logic [ReqClkW-1:0] clk_v);
    strip_beat_t b;
    b.req   = req;
    b.side  = side;
    b.strip = strip;
    b.clk_v = clk_v;
    beats_to_send = {beats_to_send, b};
    if ({1'b0, strip} < siu_q)
      in_range_queued++;
  endtask

  // register write, only issued while the block is idle
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all_regs(input logic [CfgDataW-1:0] siu,
                                input logic [CfgDataW-1:0] a_off,
                                input logic [CfgDataW-1:0] a_gain,
                                input logic [CfgDataW-1:0] c_off,
                                input logic [CfgDataW-1:0] c_gain);
    write_reg(CFG_STRIPS_IN_USE, siu);
    write_reg(CFG_ANODE_OFFSET, a_off);
    write_reg(CFG_ANODE_GAIN, a_gain);
    write_reg(CFG_CATHODE_OFFSET, c_off);
    write_reg(CFG_CATHODE_GAIN, c_gain);
    settings_seen++;
  endtask

  // wait until every beat is in and every pulse is out, then let the
  // pipeline run dry in case the last beats made no result
  task automatic settle();
    while (beats_to_send.size() != 0 || in_tvalid || pulses_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // strips mostly in range and bunched low so pulses pile up on few strips,
  // with the range edge and the whole field mixed in
  function automatic logic [StripW-1:0] pick_strip();
    int r;
    int top;
    top = (int'(siu_q) > (1 << StripW)) ? (1 << StripW) : int'(siu_q);
    r   = $urandom_range(0, 99);
    if (top == 0 || r < 8)
      return StripW'($urandom_range(0, (1 << StripW) - 1));
    if (r < 14)
      return StripW'(top - 1);
    if (r < 18)
      return StripW'((top < (1 << StripW)) ? top : top - 1);
    if (r < 45)
      return StripW'($urandom_range(0, ((top < 8) ? top : 8) - 1));
    return StripW'($urandom_range(0, top - 1));
  endfunction

  task automatic queue_noise_beat();
    queue_beat(($urandom_range(0, 9) < 3) ? REQ_FLUSH : REQ_HIT, 1'($urandom_range(0, 1)),
               pick_strip(), ReqClkW'($urandom_range(0, (1 << ReqClkW) - 1)));
  endtask

  // one readout window: a few strips sampled clock by clock, each one over
  // threshold on and off, then flushed (a flush is sometimes missing)
  task automatic queue_strip_event();
    logic [StripW-1:0] ev_strip [0:MAX_EV_STRIPS-1];
    logic              ev_side  [0:MAX_EV_STRIPS-1];
    bit                lit      [0:MAX_EV_STRIPS-1];
    int n;
    int steps;
    int t;
    int k;
    int s;
    n = $urandom_range(1, MAX_EV_STRIPS);
    for (s = 0; s < n; s++) begin
      ev_strip[s] = pick_strip();
      ev_side[s]  = 1'($urandom_range(0, 1));
      lit[s]      = 1'b1;
    end
    t     = $urandom_range(0, 700);
    steps = $urandom_range(3, 40);
    for (k = 0; k < steps && t < (1 << ReqClkW); k++) begin
      for (s = 0; s < n; s++) begin
        if (lit[s])
          queue_beat(REQ_HIT, ev_side[s], ev_strip[s], ReqClkW'(t));
        if ($urandom_range(0, 4) == 0)
          lit[s] = !lit[s];
      end
      // mostly the next clock, sometimes the same one, sometimes a jump
      if ($urandom_range(0, 9) != 0)
        t += ($urandom_range(0, 5) == 0) ? $urandom_range(2, 8) : 1;
    end
    for (s = 0; s < n; s++)
      if ($urandom_range(0, 9) != 0)
        queue_beat(REQ_FLUSH, ev_side[s], ev_strip[s],
                   ReqClkW'($urandom_range(0, (1 << ReqClkW) - 1)));
  endtask

  // n counts only beats that land on a strip in use
  task automatic queue_random(input int n);
    int target;
    target = in_range_queued + n;
    while (in_range_queued < target) begin
      if ($urandom_range(0, 99) < 85)
        queue_strip_event();
      else
        queue_noise_beat();
    end
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset values, directed cases
    settings_seen++;
    // pulse built from a repeated hit and two later hits, closed by a gap
    queue_beat(REQ_HIT,   1'b0, 11'd0,   10'd5);
    queue_beat(REQ_HIT,   1'b0, 11'd0,   10'd5);
    queue_beat(REQ_HIT,   1'b0, 11'd0,   10'd6);
    queue_beat(REQ_HIT,   1'b0, 11'd0,   10'd7);
    queue_beat(REQ_HIT,   1'b0, 11'd0,   10'd9);
    // earlier clock lowers first, then flush sends it out
    queue_beat(REQ_HIT,   1'b0, 11'd0,   10'd3);
    queue_beat(REQ_FLUSH, 1'b0, 11'd0,   10'd0);
    // flush with nothing pending
    queue_beat(REQ_FLUSH, 1'b0, 11'd0,   10'd1023);
    // widest pulse on the last strip in use, cathode side
    queue_beat(REQ_HIT,   1'b1, 11'd383, 10'd1023);
    queue_beat(REQ_HIT,   1'b1, 11'd383, 10'd0);
    queue_beat(REQ_FLUSH, 1'b1, 11'd383, 10'd0);
    // strips past the range are ignored
    queue_beat(REQ_HIT,   1'b0, 11'd384, 10'd10);
    queue_beat(REQ_FLUSH, 1'b0, 11'd384, 10'd10);
    queue_beat(REQ_HIT,   1'b1, 11'd2047, 10'd1023);
    // last clock zero never closes; a hit on the clock just after last does not close either
    queue_beat(REQ_HIT,   1'b0, 11'd1,   10'd0);
    queue_beat(REQ_HIT,   1'b0, 11'd1,   10'd50);
    queue_beat(REQ_HIT,   1'b0, 11'd1,   10'd51);
    queue_beat(REQ_HIT,   1'b0, 11'd1,   10'd53);
    queue_beat(REQ_FLUSH, 1'b1, 11'd1,   10'd0);
    // zero-width pulses, one by gap and one by flush at the top clock
    queue_beat(REQ_HIT,   1'b1, 11'd2,   10'd1000);
    queue_beat(REQ_HIT,   1'b1, 11'd2,   10'd1023);
    queue_beat(REQ_FLUSH, 1'b1, 11'd2,   10'd0);
    queue_beat(REQ_FLUSH, 1'b0, 11'd1,   10'd0);
    settle();

    // widest range, largest offsets and gains
    write_all_regs(CfgDataW'(1 << StripW), CfgDataW'((1 << OffW) - 1),
                   CfgDataW'((1 << GainW) - 1), CfgDataW'((1 << OffW) - 1),
                   CfgDataW'((1 << GainW) - 1));
    queue_random(500);
    settle();

    // single strip, zero correction; indexes past the register list dropped
    write_all_regs(CfgDataW'(1), '0, '0, '0, '0);
    for (int k = CFG_CATHODE_GAIN + 1; k < (1 << CfgIdxW); k++)
      write_reg(CfgIdxW'(k), CfgDataW'($urandom_range(0, (1 << CfgDataW) - 1)));
    queue_beat(REQ_HIT,   1'b0, 11'd0, 10'd100);
    queue_beat(REQ_HIT,   1'b0, 11'd1, 10'd100);
    queue_beat(REQ_FLUSH, 1'b0, 11'd0, 10'd0);
    queue_random(150);
    settle();

    // no strips in use: everything ignored
    write_reg(CFG_STRIPS_IN_USE, '0);
    settings_seen++;
    repeat (12) queue_noise_beat();
    settle();

    // all ones in the range register, random correction
    write_all_regs(CfgDataW'((1 << SiuW) - 1), CfgDataW'($urandom_range(0, (1 << OffW) - 1)),
                   CfgDataW'($urandom_range(0, (1 << GainW) - 1)),
                   CfgDataW'($urandom_range(0, (1 << OffW) - 1)),
                   CfgDataW'($urandom_range(0, (1 << GainW) - 1)));
    queue_random(300);
    settle();

    // random settings
    repeat (2) begin
      write_all_regs(CfgDataW'($urandom_range(1, 1 << StripW)),
                     CfgDataW'($urandom_range(0, (1 << OffW) - 1)),
                     CfgDataW'($urandom_range(0, (1 << GainW) - 1)),
                     CfgDataW'($urandom_range(0, (1 << OffW) - 1)),
                     CfgDataW'($urandom_range(0, (1 << GainW) - 1)));
      queue_random(280);
      settle();
    end

    $display("covered %0d input beats (%0d outside the strips in use) under %0d settings",
             items_in, ignored_in, settings_seen);
    $display("checked %0d pulses, %0d closed by flush, with %0d long output hold-offs",
             pulses_seen, flush_pulses, holds_done);
    if (mismatches == 0)
      $display("PASS tot_strip_hit_clustering");
    else
      $display("FAIL tot_strip_hit_clustering");
    $finish;
  end

endmodule
